FILE: hdl/spectrogram_temporal_median5_defines.svh
// Assertion macros for the temporal median filter.
// Included by the top level; needs signals clk and rst_n in scope.
`ifndef SPECTROGRAM_TEMPORAL_MEDIAN5_DEFINES_SVH
`define SPECTROGRAM_TEMPORAL_MEDIAN5_DEFINES_SVH

`ifndef SYNTH

// Check a condition at every clock edge outside reset
`define STM5_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a consequence in the same cycle
`define STM5_ASSERT_IMPLY(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Check a consequence in the next cycle
`define STM5_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`else

`define STM5_ASSERT(name, prop, msg)
`define STM5_ASSERT_IMPLY(name, pre, post, msg)
`define STM5_ASSERT_NEXT(name, pre, post, msg)

`endif

`endif

FILE: hdl/stm5_pkg.sv
// Shared widths, constants and types of the temporal median filter.
// No dependencies; used by every other file except the assertion macro header.
`timescale 1ns / 1ps

package stm5_pkg;

  localparam int MAG_W     = 16;
  localparam int IDX_W     = 10;
  localparam int CFG_W     = 11;
  localparam int FRAME_W   = 3;
  localparam int HIST_TAPS = 4;
  localparam int HIST_W    = HIST_TAPS * MAG_W;
  localparam int WIN_N     = HIST_TAPS + 1;
  localparam int APB_AW    = 2;
  localparam int APB_DW    = 32;

  // Register map
  localparam logic [APB_AW-1:0] REG_BINS_IN_USE = 2'd0;

  localparam logic [CFG_W-1:0]   BINS_RESET      = 11'd1024;
  localparam logic [FRAME_W-1:0] FRAME_FIRST_OUT = 3'd2;
  localparam logic [FRAME_W-1:0] FRAME_FULL      = 3'd4;

  typedef logic [MAG_W-1:0]  mag_t;
  typedef logic [HIST_W-1:0] hist_t;
  typedef logic [WIN_N-1:0][MAG_W-1:0] win_t;

  // Per-word control that travels with the data
  typedef struct packed {
    logic [IDX_W-1:0] bin_index;
    logic             emit;
    logic             edge_frame;
  } tag_t;

endpackage

FILE: hdl/stm5_ifs.sv
// Valid/ready channel interfaces for input and result words.
// Depends on stm5_pkg.
`timescale 1ns / 1ps

interface stm5_in_if;
  logic                valid;
  logic                ready;
  stm5_pkg::mag_t      magnitude;
  logic                start_of_track;

  modport source (output valid, output magnitude, output start_of_track, input ready);
  modport sink   (input valid, input magnitude, input start_of_track, output ready);
endinterface

interface stm5_out_if;
  logic                          valid;
  logic                          ready;
  stm5_pkg::mag_t                filtered;
  logic [stm5_pkg::IDX_W-1:0]    bin_index;
  logic                          edge_frame;

  modport source (output valid, output filtered, output bin_index, output edge_frame,
                  input ready);
  modport sink   (input valid, input filtered, input bin_index, input edge_frame,
                  output ready);
endinterface

FILE: hdl/stm5_hist.sv
// History stage: per-bin memory of the last four magnitudes, read-modify-write.
// Depends on stm5_pkg.
`timescale 1ns / 1ps

module stm5_hist #(
  parameter int MAX_BINS = 1024,
  parameter int AW       = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  logic [AW-1:0]    in_addr,
  input  stm5_pkg::mag_t   in_mag,
  input  stm5_pkg::tag_t   in_tag,
  output logic             in_ready,
  output logic             dn_valid,
  input  logic             dn_ready,
  output stm5_pkg::win_t   dn_win,
  output stm5_pkg::tag_t   dn_tag
);
  import stm5_pkg::*;

  hist_t         mem [MAX_BINS];
  hist_t         rd_r;
  hist_t         fwd_word_r;
  hist_t         hist_word;
  hist_t         new_word;
  logic          s1_valid_r;
  logic          fwd_hit_r;
  logic          s1_go;
  logic [AW-1:0] s1_addr_r;
  mag_t          s1_mag_r;
  tag_t          s1_tag_r;

  // Words that make no result leave without waiting on the median pipe
  assign s1_go    = !s1_valid_r || !s1_tag_r.emit || dn_ready;
  assign in_ready = s1_go;
  assign dn_valid = s1_valid_r && s1_tag_r.emit;
  assign dn_tag   = s1_tag_r;

  // Take the word written back on the same edge as our read
  assign hist_word = fwd_hit_r ? fwd_word_r : rd_r;
  assign new_word  = {hist_word[HIST_W-MAG_W-1:0], s1_mag_r};

  // Split history into the median window, current magnitude last
  always_comb begin
    for (int k = 0; k < HIST_TAPS; k++) begin
      dn_win[k] = hist_word[k*MAG_W +: MAG_W];
    end
    dn_win[HIST_TAPS] = s1_mag_r;
  end

  // Write back the shifted history as the word leaves
  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_go) begin
      mem[s1_addr_r] <= new_word;
    end
  end

  // Registered read at accept
  always_ff @(posedge clk) begin
    if (take) begin
      rd_r <= mem[in_addr];
    end
  end

  // Stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Stage payload and forward capture
  always_ff @(posedge clk) begin
    if (take) begin
      s1_addr_r  <= in_addr;
      s1_mag_r   <= in_mag;
      s1_tag_r   <= in_tag;
      fwd_hit_r  <= s1_valid_r && (s1_addr_r == in_addr);
      fwd_word_r <= new_word;
    end
  end

endmodule

FILE: hdl/stm5_median.sv
// Median-of-five compare network in three stages plus the output register.
// Depends on stm5_pkg and stm5_ifs.
`timescale 1ns / 1ps

module stm5_median (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  stm5_pkg::win_t   up_win,
  input  stm5_pkg::tag_t   up_tag,
  stm5_out_if.source       out_ch
);
  import stm5_pkg::*;

  function automatic mag_t mag_min(input mag_t a, input mag_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic mag_t mag_max(input mag_t a, input mag_t b);
    return (a < b) ? b : a;
  endfunction

  logic v2_r, v3_r, v4_r, ov_r;
  logic go2, go3, go4, ogo;

  mag_t a_lo_r, a_hi_r, b_lo_r, b_hi_r, e2_r;
  tag_t tag2_r;
  mag_t p3_r, q3_r, r3_r, e3_r;
  tag_t tag3_r;
  mag_t p4_r, q4_r, rl4_r, rh4_r;
  tag_t tag4_r;
  mag_t filt_r;
  logic [IDX_W-1:0] idx_r;
  logic edge_r;

  mag_t p3_nxt, q3_nxt, r3_nxt, med;

  // Ready chain: a stage moves when empty or when the next one moves
  assign ogo      = !ov_r || out_ch.ready;
  assign go4      = !v4_r || ogo;
  assign go3      = !v3_r || go4;
  assign go2      = !v2_r || go3;
  assign up_ready = go2;

  // Drop the smaller pair minimum; it sits below at least three others
  always_comb begin
    if (a_lo_r < b_lo_r) begin
      p3_nxt = b_lo_r;
      q3_nxt = b_hi_r;
      r3_nxt = a_hi_r;
    end else begin
      p3_nxt = a_lo_r;
      q3_nxt = a_hi_r;
      r3_nxt = b_hi_r;
    end
  end

  // Second smallest of the remaining four
  assign med = (p4_r < rl4_r) ? mag_min(q4_r, rl4_r) : mag_min(p4_r, rh4_r);

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (go2) v2_r <= up_valid;
      if (go3) v3_r <= v2_r;
      if (go4) v4_r <= v3_r;
      if (ogo) ov_r <= v4_r;
    end
  end

  // Stage 2: sort the two history pairs
  always_ff @(posedge clk) begin
    if (go2 && up_valid) begin
      a_lo_r <= mag_min(up_win[0], up_win[1]);
      a_hi_r <= mag_max(up_win[0], up_win[1]);
      b_lo_r <= mag_min(up_win[2], up_win[3]);
      b_hi_r <= mag_max(up_win[2], up_win[3]);
      e2_r   <= up_win[HIST_TAPS];
      tag2_r <= up_tag;
    end
  end

  // Stage 3: keep one sorted pair and the other maximum
  always_ff @(posedge clk) begin
    if (go3 && v2_r) begin
      p3_r   <= p3_nxt;
      q3_r   <= q3_nxt;
      r3_r   <= r3_nxt;
      e3_r   <= e2_r;
      tag3_r <= tag2_r;
    end
  end

  // Stage 4: sort the leftover maximum against the current magnitude
  always_ff @(posedge clk) begin
    if (go4 && v3_r) begin
      p4_r   <= p3_r;
      q4_r   <= q3_r;
      rl4_r  <= mag_min(r3_r, e3_r);
      rh4_r  <= mag_max(r3_r, e3_r);
      tag4_r <= tag3_r;
    end
  end

  // Output register; edge frames are forced to zero
  always_ff @(posedge clk) begin
    if (ogo && v4_r) begin
      filt_r <= tag4_r.edge_frame ? '0 : med;
      idx_r  <= tag4_r.bin_index;
      edge_r <= tag4_r.edge_frame;
    end
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.filtered   = filt_r;
  assign out_ch.bin_index  = idx_r;
  assign out_ch.edge_frame = edge_r;

endmodule

FILE: hdl/spectrogram_temporal_median5.sv
// Top level of the 5-tap temporal median filter: APB register, bin and frame
// counters, history stage and median pipeline. Depends on stm5_pkg, stm5_ifs,
// stm5_hist, stm5_median and the assertion macro header.
//
//   channel   direction  handshake               payload
//   in_ch     sink       valid/ready             magnitude, start_of_track
//   out_ch    source     valid/ready             filtered, bin_index, edge_frame
//   apb       slave      psel/penable, pready=1  bins_in_use at offset 0
//
// One word is accepted per cycle while no stalled result holds the input; a result
// passes the history read at the accept, then three compare stages and the output
// register.
// The per-bin history memory has one write and one registered read per cycle;
// a write-back on the same edge as a read of the same bin is forwarded.
// Reset clears the counters and valid bits and holds off the input; the history
// needs no clearing pass.
// A stall at out_ch holds every full stage; words that make no result pass the
// history stage without waiting on the compare stages.
`timescale 1ns / 1ps
`include "spectrogram_temporal_median5_defines.svh"

module spectrogram_temporal_median5 #(
  parameter int MAX_BINS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  stm5_in_if.sink                       in_ch,
  stm5_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [stm5_pkg::APB_AW-1:0]   paddr,
  input  logic [stm5_pkg::APB_DW-1:0]   pwdata,
  output logic [stm5_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import stm5_pkg::*;

  localparam int AW = $clog2(MAX_BINS);
  localparam int CW = ((AW > CFG_W) ? AW : CFG_W) + 1;

  logic [CFG_W-1:0]   bins_r;
  logic [AW-1:0]      bin_cnt_r, bin_cnt_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic [CW-1:0]      lim;
  logic [CW-1:0]      bin_inc;
  logic [AW-1:0]      cur_bin;
  logic [FRAME_W-1:0] cur_frame;
  logic               cfg_wr;
  logic               take;
  logic               wrap;
  logic               hist_ready;
  logic               med_valid;
  logic               med_ready;
  logic               sot_take;
  logic               out_stall;
  tag_t               cur_tag;
  win_t               med_win;
  tag_t               med_tag;

  // Config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == REG_BINS_IN_USE);
  assign prdata = (paddr == REG_BINS_IN_USE) ? APB_DW'(bins_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bins_r <= BINS_RESET;
    end else if (cfg_wr) begin
      bins_r <= pwdata[CFG_W-1:0];
    end
  end

  // Clamp the bin count to 1..MAX_BINS
  always_comb begin
    if (bins_r == '0) begin
      lim = CW'(1);
    end else if (CW'(bins_r) > CW'(MAX_BINS)) begin
      lim = CW'(MAX_BINS);
    end else begin
      lim = CW'(bins_r);
    end
  end

  // Position of the incoming word; a track start restarts both counts
  assign take      = in_ch.valid && in_ch.ready;
  assign cur_bin   = in_ch.start_of_track ? '0 : bin_cnt_r;
  assign cur_frame = in_ch.start_of_track ? '0 : frame_r;
  assign bin_inc   = CW'(cur_bin) + CW'(1);
  assign wrap      = (bin_inc >= lim);

  always_comb begin
    bin_cnt_nxt = bin_cnt_r;
    frame_nxt   = frame_r;
    if (take) begin
      if (wrap) begin
        bin_cnt_nxt = '0;
        frame_nxt   = (cur_frame < FRAME_FULL) ? cur_frame + FRAME_W'(1) : cur_frame;
      end else begin
        bin_cnt_nxt = bin_inc[AW-1:0];
        frame_nxt   = cur_frame;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_cnt_r <= '0;
      frame_r   <= '0;
    end else begin
      bin_cnt_r <= bin_cnt_nxt;
      frame_r   <= frame_nxt;
    end
  end

  // Result flags: nothing for the first two frames, zero for the next two
  always_comb begin
    cur_tag.bin_index  = IDX_W'(cur_bin);
    cur_tag.emit       = (cur_frame >= FRAME_FIRST_OUT);
    cur_tag.edge_frame = (cur_frame >= FRAME_FIRST_OUT) && (cur_frame < FRAME_FULL);
  end

  // Hold off the input while in reset
  assign in_ch.ready = hist_ready && rst_n;

  stm5_hist #(
    .MAX_BINS (MAX_BINS),
    .AW       (AW)
  ) u_hist (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .in_addr  (cur_bin),
    .in_mag   (in_ch.magnitude),
    .in_tag   (cur_tag),
    .in_ready (hist_ready),
    .dn_valid (med_valid),
    .dn_ready (med_ready),
    .dn_win   (med_win),
    .dn_tag   (med_tag)
  );

  stm5_median u_median (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (med_valid),
    .up_ready (med_ready),
    .up_win   (med_win),
    .up_tag   (med_tag),
    .out_ch   (out_ch)
  );

  assign sot_take  = take && in_ch.start_of_track;
  assign out_stall = out_ch.valid && !out_ch.ready;

  // Frame count saturates at four
  `STM5_ASSERT(a_frame_sat, frame_r <= FRAME_FULL, "frame count above four")
  // A track start leaves the bin count at one, or at zero on a one-bin frame
  `STM5_ASSERT_NEXT(a_start_restart, sot_take, bin_cnt_r <= AW'(1), "bin count not restarted")
  // Frame count moves only on an accepted word
  `STM5_ASSERT_NEXT(a_frame_hold, !take, $stable(frame_r), "frame count moved without a word")
  // Input stalls only behind a stalled result
  `STM5_ASSERT_IMPLY(a_stall_src, !in_ch.ready, out_stall, "input stalled while output free")

endmodule
